>>> design/lrupr_pkg.sv
// Shared constants and control types for the LRU page replacement unit.
`timescale 1ns / 1ps
package lrupr_pkg;

  localparam int FRAMES  = 4;
  localparam int PAGE_W  = 16;
  localparam int COUNT_W = 16;
  localparam int IDX_W   = (FRAMES > 1) ? $clog2(FRAMES) : 1;
  localparam int USED_W  = $clog2(FRAMES + 1);

  typedef struct packed {
    logic load;
    logic compare;
    logic update;
  } lrupr_cmd_t;

endpackage

>>> design/lru_page_replacement_unit.sv
// LRU page replacement unit: top level joining sequencer and datapath.
// Each page reference is a transfer taken on start when busy is low. The unit
// keeps FRAMES resident pages in recency order in flip-flops and handles each
// reference in steps: capture, a parallel compare against all occupied frames,
// and the recency shift with the fault count update. The result then sits on
// the result ports for one cycle marked by done_o, and in that same cycle busy
// is low so the next reference can be taken; none is taken before then.
// done_o cannot be held off, so the receiver must take each result as it
// comes. fault_total_o wraps at 16 bits.
`timescale 1ns / 1ps
module lru_page_replacement_unit (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start,
  output logic                          busy,
  input  logic [lrupr_pkg::PAGE_W-1:0]  page_i,
  output logic                          done_o,
  output logic                          hit_o,
  output logic                          evicted_valid_o,
  output logic [lrupr_pkg::PAGE_W-1:0]  evicted_page_o,
  output logic [lrupr_pkg::COUNT_W-1:0] fault_total_o
);
  import lrupr_pkg::*;

  lrupr_cmd_t cmd;

  lrupr_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .busy   (busy),
    .cmd_o  (cmd)
  );

  lrupr_datapath u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .page_i          (page_i),
    .done_o          (done_o),
    .hit_o           (hit_o),
    .evicted_valid_o (evicted_valid_o),
    .evicted_page_o  (evicted_page_o),
    .fault_total_o   (fault_total_o)
  );

endmodule

>>> design/lrupr_ctrl.sv
// Sequencer for the LRU unit: capture, compare, update.
`timescale 1ns / 1ps
module lrupr_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start,
  output logic                busy,
  output lrupr_pkg::lrupr_cmd_t cmd_o
);
  import lrupr_pkg::*;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_CMP  = 2'd1;
  localparam logic [1:0] ST_UPD  = 2'd2;

  logic [1:0] state_q, state_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      ST_IDLE: begin
        if (start) begin
          cmd_o.load = 1'b1;
          state_d    = ST_CMP;
        end
      end
      ST_CMP: begin
        cmd_o.compare = 1'b1;
        state_d       = ST_UPD;
      end
      ST_UPD: begin
        cmd_o.update = 1'b1;
        state_d      = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  assign busy = (state_q != ST_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

>>> design/lrupr_datapath.sv
// Frame store, parallel page compare, recency shift and fault counter.
`timescale 1ns / 1ps
module lrupr_datapath (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  lrupr_pkg::lrupr_cmd_t         cmd_i,
  input  logic [lrupr_pkg::PAGE_W-1:0]  page_i,
  output logic                          done_o,
  output logic                          hit_o,
  output logic                          evicted_valid_o,
  output logic [lrupr_pkg::PAGE_W-1:0]  evicted_page_o,
  output logic [lrupr_pkg::COUNT_W-1:0] fault_total_o
);
  import lrupr_pkg::*;

  logic [PAGE_W-1:0]  page_q;
  logic [PAGE_W-1:0]  frame_q [FRAMES];
  logic [PAGE_W-1:0]  frame_d [FRAMES];
  logic [USED_W-1:0]  used_q, used_d;
  logic [COUNT_W-1:0] fault_q, fault_d;
  logic               match_q, match_d;
  logic [IDX_W-1:0]   pos_q, pos_d;
  logic               full;
  logic [IDX_W-1:0]   from_idx, last_idx;

  logic               done_q;
  logic               hit_q;
  logic               ev_valid_q;
  logic [PAGE_W-1:0]  ev_page_q;

  // parallel lookup over occupied frames
  always_comb begin
    match_d = 1'b0;
    pos_d   = '0;
    for (int k = 0; k < FRAMES; k++) begin
      if ((USED_W'(k) < used_q) && (frame_q[k] == page_q)) begin
        match_d = 1'b1;
        pos_d   = IDX_W'(k);
      end
    end
  end

  assign full = (used_q == USED_W'(FRAMES));

  // shift window: from_idx+1..last_idx move toward head, page lands at last_idx
  always_comb begin
    if (match_q) begin
      from_idx = pos_q;
      last_idx = IDX_W'(used_q - USED_W'(1));
    end else if (full) begin
      from_idx = '0;
      last_idx = IDX_W'(FRAMES - 1);
    end else begin
      from_idx = used_q[IDX_W-1:0];
      last_idx = used_q[IDX_W-1:0];
    end
  end

  always_comb begin
    for (int k = 0; k < FRAMES; k++) begin
      frame_d[k] = frame_q[k];
      if (IDX_W'(k) == last_idx) begin
        frame_d[k] = page_q;
      end else if (k < FRAMES - 1) begin
        if ((IDX_W'(k) >= from_idx) && (IDX_W'(k) < last_idx)) begin
          frame_d[k] = frame_q[(k < FRAMES - 1) ? k + 1 : k];
        end
      end
    end
  end

  always_comb begin
    used_d  = used_q;
    fault_d = fault_q;
    if (cmd_i.update && !match_q) begin
      fault_d = fault_q + COUNT_W'(1);
      if (!full) begin
        used_d = used_q + USED_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      page_q <= page_i;
    end
    if (cmd_i.compare) begin
      match_q <= match_d;
      pos_q   <= pos_d;
    end
    if (cmd_i.update) begin
      frame_q    <= frame_d;
      hit_q      <= match_q;
      ev_valid_q <= !match_q && full;
      ev_page_q  <= (!match_q && full) ? frame_q[0] : '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      used_q  <= '0;
      fault_q <= '0;
      done_q  <= 1'b0;
    end else begin
      used_q  <= used_d;
      fault_q <= fault_d;
      done_q  <= cmd_i.update;
    end
  end

  assign done_o          = done_q;
  assign hit_o           = hit_q;
  assign evicted_valid_o = ev_valid_q;
  assign evicted_page_o  = ev_page_q;
  assign fault_total_o   = fault_q;

endmodule

>>> dv/tb.sv
// Self-checking testbench for the LRU page replacement unit.
`timescale 1ns / 1ps
module tb;
  import lrupr_pkg::*;

  localparam int WATCHDOG_LIMIT = 1000;
  localparam int MAX_GAP        = 40;
  localparam int PHASE_ITEMS    = 375;
  localparam int POOL_SIZE      = 6;

  typedef struct packed {
    logic               hit;
    logic               evicted_valid;
    logic [PAGE_W-1:0]  evicted_page;
    logic [COUNT_W-1:0] fault_total;
  } lru_result_t;

  typedef struct packed {
    logic [PAGE_W-1:0] page;
    logic              typed;
    lru_result_t       res;
  } ref_row_t;

  typedef struct packed {
    logic        typed;
    lru_result_t res;
  } row_exp_t;

  logic                clk_i;
  logic                rst_ni;
  logic                start;
  logic                busy;
  logic [PAGE_W-1:0]   page_i;
  logic                done_o;
  logic                hit_o;
  logic                evicted_valid_o;
  logic [PAGE_W-1:0]   evicted_page_o;
  logic [COUNT_W-1:0]  fault_total_o;

  // Predictor state: resident pages, LRU at index 0.
  logic [PAGE_W-1:0]  resident [FRAMES];
  int unsigned        resident_cnt;
  logic [COUNT_W-1:0] faults_seen;

  lru_result_t expected_results [$];
  row_exp_t    typed_rows [$];
  int unsigned mismatches;
  int unsigned idle_cycles;

  // Directed references; typed expectations checked directly, others via predictor.
  ref_row_t dir_rows [20] = '{
    '{16'h0000, 1'b1, '{1'b0, 1'b0, 16'h0000, 16'd1}},
    '{16'hFFFF, 1'b1, '{1'b0, 1'b0, 16'h0000, 16'd2}},
    '{16'h0000, 1'b1, '{1'b1, 1'b0, 16'h0000, 16'd2}},
    '{16'h8000, 1'b1, '{1'b0, 1'b0, 16'h0000, 16'd3}},
    '{16'h0001, 1'b1, '{1'b0, 1'b0, 16'h0000, 16'd4}},
    '{16'hFFFF, 1'b1, '{1'b1, 1'b0, 16'h0000, 16'd4}},
    '{16'h1234, 1'b1, '{1'b0, 1'b1, 16'h0000, 16'd5}},
    '{16'h5555, 1'b1, '{1'b0, 1'b1, 16'h8000, 16'd6}},
    '{16'h5555, 1'b1, '{1'b1, 1'b0, 16'h0000, 16'd6}},
    '{16'hFFFF, 1'b0, '0},
    '{16'hAAAA, 1'b0, '0},
    '{16'h0000, 1'b0, '0},
    '{16'h0000, 1'b0, '0},
    '{16'h7FFF, 1'b0, '0},
    '{16'hFFFF, 1'b0, '0},
    '{16'hAAAA, 1'b0, '0},
    '{16'h0000, 1'b0, '0},
    '{16'h7FFF, 1'b0, '0},
    '{16'h0100, 1'b0, '0},
    '{16'h0001, 1'b0, '0}
  };

  lru_page_replacement_unit DUT (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .start           (start),
    .busy            (busy),
    .page_i          (page_i),
    .done_o          (done_o),
    .hit_o           (hit_o),
    .evicted_valid_o (evicted_valid_o),
    .evicted_page_o  (evicted_page_o),
    .fault_total_o   (fault_total_o)
  );

  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  function automatic lru_result_t lookup_page(input logic [PAGE_W-1:0] pg);
    lru_result_t r;
    bit          found;
    int unsigned pos;
    r     = '0;
    found = 1'b0;
    pos   = 0;
    for (int unsigned k = 0; k < resident_cnt; k++) begin
      if (resident[k] == pg) begin
        found = 1'b1;
        pos   = k;
      end
    end
    if (found) begin
      r.hit = 1'b1;
      for (int unsigned k = pos; k + 1 < resident_cnt; k++) resident[k] = resident[k + 1];
      resident[resident_cnt - 1] = pg;
    end else if (resident_cnt < FRAMES) begin
      resident[resident_cnt] = pg;
      resident_cnt++;
      faults_seen++;
    end else begin
      r.evicted_valid = 1'b1;
      r.evicted_page  = resident[0];
      for (int unsigned k = 0; k + 1 < FRAMES; k++) resident[k] = resident[k + 1];
      resident[FRAMES - 1] = pg;
      faults_seen++;
    end
    r.fault_total = faults_seen;
    return r;
  endfunction

  // Result checking and prediction on each accepted reference.
  always @(posedge clk_i) begin
    lru_result_t want;
    lru_result_t pred;
    row_exp_t    row;
    bit          moved;
    moved = 1'b0;
    if (rst_ni) begin
      if (done_o === 1'b1) begin
        moved = 1'b1;
        if (expected_results.size() == 0) begin
          $error("result strobe with no reference pending");
          mismatches++;
        end else begin
          want = expected_results.pop_front();
          if (hit_o !== want.hit) begin
            $error("hit: expected %0d, got %0d", want.hit, hit_o);
            mismatches++;
          end
          if (evicted_valid_o !== want.evicted_valid) begin
            $error("evicted_valid: expected %0d, got %0d", want.evicted_valid,
                   evicted_valid_o);
            mismatches++;
          end
          if (evicted_page_o !== want.evicted_page) begin
            $error("evicted_page: expected %h, got %h", want.evicted_page, evicted_page_o);
            mismatches++;
          end
          if (fault_total_o !== want.fault_total) begin
            $error("fault_total: expected %0d, got %0d", want.fault_total, fault_total_o);
            mismatches++;
          end
        end
      end
      if (start && busy === 1'b0) begin
        moved = 1'b1;
        pred  = lookup_page(page_i);
        if (typed_rows.size() != 0) begin
          row = typed_rows.pop_front();
          expected_results.push_back(row.typed ? row.res : pred);
        end else begin
          expected_results.push_back(pred);
        end
      end
      idle_cycles = moved ? 0 : idle_cycles + 1;
    end
  end

  initial begin
    wait (idle_cycles >= WATCHDOG_LIMIT);
    $display("tb: FAIL");
    $finish;
  end

  task automatic send_page(input logic [PAGE_W-1:0] pg, input int unsigned idle_pct,
                           input logic typed, input lru_result_t typed_res);
    int unsigned gap;
    gap = 0;
    while (gap < MAX_GAP && $urandom_range(99) < idle_pct) gap++;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    typed_rows.push_back('{typed, typed_res});
    start  <= 1'b1;
    page_i <= pg;
    do @(posedge clk_i); while (busy !== 1'b0);
  endtask

  // Hold off new references until every pending result has come back.
  task automatic drain_results();
    start <= 1'b0;
    @(posedge clk_i);
    while (expected_results.size() != 0) @(posedge clk_i);
  endtask

  initial begin
    int unsigned       idle_pct [4];
    logic [PAGE_W-1:0] pool [POOL_SIZE];
    logic [PAGE_W-1:0] pg;
    idle_pct     = '{0, 65, 0, 21};
    rst_ni       = 1'b0;
    start        = 1'b0;
    page_i       = '0;
    resident     = '{default: '0};
    resident_cnt = 0;
    faults_seen  = '0;
    mismatches   = 0;
    idle_cycles  = 0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_rows[i]) send_page(dir_rows[i].page, 0, dir_rows[i].typed, dir_rows[i].res);
    drain_results();

    // Small working set per phase so hits, refills and evictions all occur often.
    foreach (idle_pct[p]) begin
      foreach (pool[j]) pool[j] = PAGE_W'($urandom_range(65535));
      pool[0] = $urandom_range(1) ? '1 : '0;
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if ($urandom_range(9) < 7) pg = pool[$urandom_range(POOL_SIZE - 1)];
        else pg = PAGE_W'($urandom_range(65535));
        send_page(pg, idle_pct[p], 1'b0, '0);
      end
      drain_results();
    end

    repeat (6) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("tb: PASS");
    end else begin
      $display("tb: FAIL");
    end
    $finish;
  end

endmodule

>>> filelist.f
design/lrupr_pkg.sv
design/lrupr_ctrl.sv
design/lrupr_datapath.sv
design/lru_page_replacement_unit.sv
dv/tb.sv
